FILE: rtl/tlptm_pkg.sv
package tlptm_pkg;

    // Field widths of one item.
    localparam int ADDR_W = 32;
    localparam int FLAG_W = 12;
    localparam int CMD_W  = 2;

    // Address split for 4 KiB pages with a two-level walk.
    localparam int IDX_W     = 10;
    localparam int OFS_W     = 12;
    localparam int DIR_SHIFT = 22;
    localparam int TBL_SHIFT = 12;
    localparam int DIR_DEPTH = 1024;

    // Command codes; the fourth code has no meaning.
    localparam logic [CMD_W-1:0] CMD_MAP   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UNMAP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_XLATE = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] virt_addr;
        logic [ADDR_W-1:0] frame_addr;
        logic [FLAG_W-1:0] page_flags;
    } t_req;

    typedef struct packed {
        logic [ADDR_W-1:0] phys_result;
        logic              mapped;
        logic              status;
    } t_rsp;

    // Source of the result that the datapath stages.
    typedef enum logic [1:0] {
        RES_ZERO  = 2'd0,
        RES_FAIL  = 2'd1,
        RES_XLATE = 2'd2
    } t_res_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     capture;
        logic     dir_init;
        logic     dir_wr;
        logic     alloc;
        logic     cnt_inc;
        logic     tbl_wr;
        logic     tbl_rd;
        logic     tbl_from_reg;
        logic     idx_from_cnt;
        logic     tbl_zero;
        logic     res_load;
        t_res_sel res_sel;
        logic     out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             present;
        logic             pool_full;
        logic             cnt_last;
    } t_dp_sts;

endpackage

FILE: rtl/tlptm_if.sv
// Request channel: one command item.
interface tlptm_req_if;
    import tlptm_pkg::*;

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// Response channel: one result item.
interface tlptm_rsp_if;
    import tlptm_pkg::*;

    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/tlptm_ctrl.sv
module tlptm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  tlptm_pkg::t_dp_sts i_sts,
    output tlptm_pkg::t_dp_cmd o_cmd
);
    import tlptm_pkg::*;

    typedef enum logic [6:0] {
        S_INIT = 7'b0000001,
        S_IDLE = 7'b0000010,
        S_DEC  = 7'b0000100,
        S_TCLR = 7'b0001000,
        S_TWR  = 7'b0010000,
        S_TCHK = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_vld;
    logic   n_out_vld;

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.res_sel = RES_ZERO;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.dir_init = 1'b1;
                o_cmd.cnt_inc  = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DEC;
                end
            end
            S_DEC: begin
                n_state        = S_DONE;
                o_cmd.res_load = 1'b1;
                unique case (i_sts.cmd)
                    CMD_MAP: begin
                        if (i_sts.present) begin
                            o_cmd.tbl_wr = 1'b1;
                        end else if (i_sts.pool_full) begin
                            o_cmd.res_sel = RES_FAIL;
                        end else begin
                            o_cmd.res_load = 1'b0;
                            o_cmd.dir_wr   = 1'b1;
                            o_cmd.alloc    = 1'b1;
                            n_state        = S_TCLR;
                        end
                    end
                    CMD_UNMAP: begin
                        o_cmd.tbl_wr = i_sts.present;
                    end
                    CMD_XLATE: begin
                        if (i_sts.present) begin
                            o_cmd.res_load = 1'b0;
                            o_cmd.tbl_rd   = 1'b1;
                            n_state        = S_TCHK;
                        end
                    end
                    default: begin
                        o_cmd.res_load = 1'b1;
                    end
                endcase
            end
            S_TCLR: begin
                o_cmd.tbl_wr       = 1'b1;
                o_cmd.tbl_from_reg = 1'b1;
                o_cmd.idx_from_cnt = 1'b1;
                o_cmd.tbl_zero     = 1'b1;
                o_cmd.cnt_inc      = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = S_TWR;
                end
            end
            S_TWR: begin
                o_cmd.tbl_wr       = 1'b1;
                o_cmd.tbl_from_reg = 1'b1;
                o_cmd.res_load     = 1'b1;
                n_state            = S_DONE;
            end
            S_TCHK: begin
                o_cmd.res_load = 1'b1;
                o_cmd.res_sel  = RES_XLATE;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (!r_out_vld || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    // The output register holds a result until the sink takes it.
    always_comb begin
        n_out_vld = r_out_vld;
        if (o_cmd.out_load) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_out_valid = r_out_vld;

    // A result never overwrites one that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_vld || i_out_ready))
        else $error("result register overwritten");

    // A table clear runs until the counter reaches its last index.
    a_clear_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TCLR && !i_sts.cnt_last) |=> (r_state == S_TCLR))
        else $error("table clear cut short");

    // An allocation is always followed by a clear of the new table.
    a_alloc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.alloc |=> (r_state == S_TCLR))
        else $error("allocation without table clear");

endmodule

FILE: rtl/tlptm_dp.sv
module tlptm_dp #(
    parameter int TABLE_POOL = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tlptm_pkg::t_req    i_req_data,
    input  tlptm_pkg::t_dp_cmd i_cmd,
    output tlptm_pkg::t_dp_sts o_sts,
    output tlptm_pkg::t_rsp    o_rsp_data
);
    import tlptm_pkg::*;

    localparam int TW      = (TABLE_POOL > 1) ? $clog2(TABLE_POOL) : 1;
    localparam int UW      = $clog2(TABLE_POOL + 1);
    localparam int TA_W    = TW + IDX_W;
    localparam int T_DEPTH = TABLE_POOL * DIR_DEPTH;

    // Directory entry: present bit on top of the table number.
    logic [TW:0]       r_dir_mem [DIR_DEPTH];
    logic [TW:0]       r_dir_q;
    logic [ADDR_W-1:0] r_tbl_mem [T_DEPTH];
    logic [ADDR_W-1:0] r_tbl_q;

    t_req              r_req;
    logic [UW-1:0]     r_used;
    logic [TW-1:0]     r_tbl;
    logic [IDX_W-1:0]  r_cnt;
    t_rsp              r_res;
    t_rsp              r_out;

    logic [IDX_W-1:0]  req_di;
    logic [IDX_W-1:0]  req_ti;
    logic [IDX_W-1:0]  in_di;
    logic [IDX_W-1:0]  dir_waddr;
    logic [TW:0]       dir_wdata;
    logic [TW-1:0]     tsel;
    logic [IDX_W-1:0]  isel;
    logic [TA_W-1:0]   taddr;
    logic [ADDR_W-1:0] twdata;
    logic              pool_full;
    t_rsp              res_next;

    assign req_di = r_req.virt_addr[DIR_SHIFT +: IDX_W];
    assign req_ti = r_req.virt_addr[TBL_SHIFT +: IDX_W];
    assign in_di  = i_req_data.virt_addr[DIR_SHIFT +: IDX_W];

    // Command capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req_data;
        end
    end

    // Pool counter and shared sweep counter.
    assign pool_full = (r_used == UW'(TABLE_POOL));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_cmd.alloc) begin
                r_used <= r_used + UW'(1);
                r_cnt  <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.alloc) begin
            r_tbl <= r_used[TW-1:0];
        end
    end

    // Directory memory: cleared by a sweep after reset, read at capture.
    assign dir_waddr = i_cmd.dir_init ? r_cnt : req_di;
    assign dir_wdata = i_cmd.dir_init ? '0 : {1'b1, r_used[TW-1:0]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.dir_init || i_cmd.dir_wr) begin
            r_dir_mem[dir_waddr] <= dir_wdata;
        end
        if (i_cmd.capture) begin
            r_dir_q <= r_dir_mem[in_di];
        end
    end

    // Table memory address and write data.
    assign tsel   = i_cmd.tbl_from_reg ? r_tbl : r_dir_q[TW-1:0];
    assign isel   = i_cmd.idx_from_cnt ? r_cnt : req_ti;
    assign taddr  = {tsel, isel};
    assign twdata = (i_cmd.tbl_zero || r_req.cmd != CMD_MAP) ? '0
                  : {r_req.frame_addr[ADDR_W-1:OFS_W], r_req.page_flags};

    always_ff @(posedge i_clk) begin
        if (i_cmd.tbl_wr) begin
            r_tbl_mem[taddr] <= twdata;
        end
        if (i_cmd.tbl_rd) begin
            r_tbl_q <= r_tbl_mem[taddr];
        end
    end

    // Result staging and output register.
    always_comb begin
        res_next = '0;
        case (i_cmd.res_sel)
            RES_FAIL: begin
                res_next.status = 1'b1;
            end
            RES_XLATE: begin
                if (r_tbl_q[0]) begin
                    res_next.mapped      = 1'b1;
                    res_next.phys_result = {r_tbl_q[ADDR_W-1:OFS_W],
                                            r_req.virt_addr[OFS_W-1:0]};
                end
            end
            default: begin
                res_next = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_res <= res_next;
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_rsp_data      = r_out;
    assign o_sts.cmd       = r_req.cmd;
    assign o_sts.present   = r_dir_q[TW];
    assign o_sts.pool_full = pool_full;
    assign o_sts.cnt_last  = (r_cnt == {IDX_W{1'b1}});

    // No table is handed out once the pool is empty.
    a_alloc_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.alloc |-> !pool_full)
        else $error("allocation from an exhausted pool");

    // The pool count never passes the pool size.
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(TABLE_POOL))
        else $error("pool count out of range");

    // Table reads serve translate commands only.
    a_read_xlate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.tbl_rd |-> (r_req.cmd == CMD_XLATE && !i_cmd.tbl_wr))
        else $error("table read outside translate");

endmodule

FILE: rtl/two_level_page_table_manager_core.sv
// Sequence: map or unmap of an address whose table is present, translate that misses
// and unknown commands stage their result in the decode state; a translate hit first
// reads the table memory. A map that allocates a table first clears it in the table
// memory, one entry a cycle. A new item is taken only once the result of the last is
// loaded into the output register, which waits while the sink is not ready. After
// reset the directory is cleared, during which no item is accepted.
module two_level_page_table_manager_core #(
    parameter int TABLE_POOL = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tlptm_req_if.sink         i_req,
    tlptm_rsp_if.source       o_rsp
);
    import tlptm_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // Sequencing of one command.
    tlptm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    // Directory, table pool and result registers.
    tlptm_dp #(
        .TABLE_POOL (TABLE_POOL)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_data (i_req.data),
        .i_cmd      (dp_cmd),
        .o_sts      (dp_sts),
        .o_rsp_data (o_rsp.data)
    );

endmodule
